/* design/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg
// Types and constants for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package qrm_pkg;

   localparam int QBITS = 15;
   localparam int STEPS = QBITS;
   localparam int PROD_W = 32;
   localparam int N_W = 33;
   localparam int NUM_W = 34;
   localparam int DEN_W = N_W + 1;
   localparam int DIV_W = 48;
   localparam int NENT = 9;
   localparam logic [QBITS-1:0] Q_ONE = 15'd16384;

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic               status;
   } rsp_type;

endpackage

/* design/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Normalized quaternion to 3x3 rotation matrix in Q2.14, one request a cycle while not stalled.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output is not stalled and returns
// one matrix per request, in order. Each entry is the exact ratio
// 16384*num/n (n = sum of squares), rounded to nearest with ties away from
// zero, from a 15-stage restoring divider that retires one quotient bit per
// stage for all nine entries. A zero quaternion yields the identity with
// status set. A stall at the output holds the whole pipeline.
module quaternion_to_rotation_matrix (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qrm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qrm_pkg::rsp_type rsp_data
);
   import qrm_pkg::*;

   logic advance;

   // stage 1: products
   logic v1_ff;
   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [PROD_W-1:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;

   // stage 2: norm and numerators
   logic v2_ff;
   logic [N_W-1:0] n2_ff;
   logic signed [NUM_W-1:0] num2_ff [NENT];
   logic signed [NUM_W-1:0] num2_in [NENT];
   logic [N_W-1:0] n2_in;

   // divider stages
   logic                 dv_ff   [STEPS+1];
   logic                 zero_ff [STEPS+1];
   logic [DEN_W-1:0]     den_ff  [STEPS+1];
   logic [DIV_W-1:0]     rem_ff  [STEPS+1][NENT];
   logic [QBITS-1:0]     quo_ff  [STEPS+1][NENT];
   logic [NENT-1:0]      neg_ff  [STEPS+1];
   logic [DIV_W-1:0]     rem_in  [1:STEPS][NENT];
   logic [QBITS-1:0]     quo_in  [1:STEPS][NENT];
   logic [DIV_W-1:0]     rem0_in [NENT];
   logic [NENT-1:0]      neg0_in;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   function automatic logic signed [15:0] to_q14(input logic neg, input logic [QBITS-1:0] q);
      logic [QBITS-1:0] s;
      s = (q > Q_ONE) ? Q_ONE : q;
      return neg ? -$signed({1'b0, s}) : $signed({1'b0, s});
   endfunction

   always_comb begin
      n2_in = N_W'($unsigned(xx_ff)) + N_W'($unsigned(yy_ff))
            + N_W'($unsigned(zz_ff)) + N_W'($unsigned(ww_ff));
      num2_in[0] = NUM_W'(ww_ff) + NUM_W'(xx_ff) - NUM_W'(yy_ff) - NUM_W'(zz_ff);
      num2_in[1] = (NUM_W'(xy_ff) - NUM_W'(wz_ff)) <<< 1;
      num2_in[2] = (NUM_W'(xz_ff) + NUM_W'(wy_ff)) <<< 1;
      num2_in[3] = (NUM_W'(xy_ff) + NUM_W'(wz_ff)) <<< 1;
      num2_in[4] = NUM_W'(ww_ff) - NUM_W'(xx_ff) + NUM_W'(yy_ff) - NUM_W'(zz_ff);
      num2_in[5] = (NUM_W'(yz_ff) - NUM_W'(wx_ff)) <<< 1;
      num2_in[6] = (NUM_W'(xz_ff) - NUM_W'(wy_ff)) <<< 1;
      num2_in[7] = (NUM_W'(yz_ff) + NUM_W'(wx_ff)) <<< 1;
      num2_in[8] = NUM_W'(ww_ff) - NUM_W'(xx_ff) - NUM_W'(yy_ff) + NUM_W'(zz_ff);
   end

   // dividend = mag*32768 + n, divisor = 2n
   always_comb begin
      logic [NUM_W-1:0] mag;
      for (int e = 0; e < NENT; e++) begin
         neg0_in[e] = num2_ff[e][NUM_W-1];
         mag = neg0_in[e] ? $unsigned(-num2_ff[e]) : $unsigned(num2_ff[e]);
         rem0_in[e] = (DIV_W'(mag) << QBITS) + DIV_W'(n2_ff);
      end
   end

   always_comb begin
      logic [DIV_W:0] sh;
      for (int k = 0; k < STEPS; k++) begin
         sh = (DIV_W+1)'(den_ff[k]) << (STEPS - 1 - k);
         for (int e = 0; e < NENT; e++) begin
            quo_in[k+1][e] = quo_ff[k][e];
            if ({1'b0, rem_ff[k][e]} >= sh) begin
               rem_in[k+1][e] = rem_ff[k][e] - sh[DIV_W-1:0];
               quo_in[k+1][e][STEPS-1-k] = 1'b1;
            end else begin
               rem_in[k+1][e] = rem_ff[k][e];
            end
         end
      end
   end

   always_comb begin
      rsp_data_in.m00 = to_q14(neg_ff[STEPS][0], quo_ff[STEPS][0]);
      rsp_data_in.m01 = to_q14(neg_ff[STEPS][1], quo_ff[STEPS][1]);
      rsp_data_in.m02 = to_q14(neg_ff[STEPS][2], quo_ff[STEPS][2]);
      rsp_data_in.m10 = to_q14(neg_ff[STEPS][3], quo_ff[STEPS][3]);
      rsp_data_in.m11 = to_q14(neg_ff[STEPS][4], quo_ff[STEPS][4]);
      rsp_data_in.m12 = to_q14(neg_ff[STEPS][5], quo_ff[STEPS][5]);
      rsp_data_in.m20 = to_q14(neg_ff[STEPS][6], quo_ff[STEPS][6]);
      rsp_data_in.m21 = to_q14(neg_ff[STEPS][7], quo_ff[STEPS][7]);
      rsp_data_in.m22 = to_q14(neg_ff[STEPS][8], quo_ff[STEPS][8]);
      rsp_data_in.status = zero_ff[STEPS];
      if (zero_ff[STEPS]) begin
         rsp_data_in.m00 = 16'sd16384;
         rsp_data_in.m01 = '0;
         rsp_data_in.m02 = '0;
         rsp_data_in.m10 = '0;
         rsp_data_in.m11 = 16'sd16384;
         rsp_data_in.m12 = '0;
         rsp_data_in.m20 = '0;
         rsp_data_in.m21 = '0;
         rsp_data_in.m22 = 16'sd16384;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= STEPS; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         dv_ff[0] <= v2_ff;
         for (int k = 0; k < STEPS; k++) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         rsp_valid_ff <= dv_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xx_ff <= req_data.quat_x * req_data.quat_x;
         yy_ff <= req_data.quat_y * req_data.quat_y;
         zz_ff <= req_data.quat_z * req_data.quat_z;
         ww_ff <= req_data.quat_w * req_data.quat_w;
         xy_ff <= req_data.quat_x * req_data.quat_y;
         xz_ff <= req_data.quat_x * req_data.quat_z;
         yz_ff <= req_data.quat_y * req_data.quat_z;
         wx_ff <= req_data.quat_w * req_data.quat_x;
         wy_ff <= req_data.quat_w * req_data.quat_y;
         wz_ff <= req_data.quat_w * req_data.quat_z;
         n2_ff <= n2_in;
         num2_ff <= num2_in;
         den_ff[0]  <= {n2_ff, 1'b0};
         zero_ff[0] <= (n2_ff == '0);
         neg_ff[0]  <= neg0_in;
         for (int e = 0; e < NENT; e++) begin
            rem_ff[0][e] <= rem0_in[e];
            quo_ff[0][e] <= '0;
         end
         for (int k = 0; k < STEPS; k++) begin
            den_ff[k+1]  <= den_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            for (int e = 0; e < NENT; e++) begin
               rem_ff[k+1][e] <= rem_in[k+1][e];
               quo_ff[k+1][e] <= quo_in[k+1][e];
            end
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
// Drives quaternion requests in random bursts while the output stalls on its
// own pattern. Each accepted request is turned into an expected matrix by an
// exact integer computation of every entry as a rounded ratio, and each
// returned matrix is compared as a whole with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
   import qrm_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type matrix_queue[$];
   int      mismatch_count = 0;
   int      unexpected_count = 0;
   int      idle_cycles = 0;
   int      burst_left;
   int      stall_mode = 0;

   quaternion_to_rotation_matrix DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round(16384 * num / n), ties away from zero, saturated
   function automatic logic signed [15:0] rounded_ratio(longint num, longint n);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag * 16384 + n) / (2 * n);
      if (q > 16384) q = 16384;
      return (num < 0) ? 16'(-q) : 16'(q);
   endfunction

   function automatic rsp_type rotation_of(req_type q);
      rsp_type r;
      longint x, y, z, w, n;
      x = q.quat_x;
      y = q.quat_y;
      z = q.quat_z;
      w = q.quat_w;
      n = x*x + y*y + z*z + w*w;
      r = '0;
      if (n == 0) begin
         r.m00 = 16'sd16384;
         r.m11 = 16'sd16384;
         r.m22 = 16'sd16384;
         r.status = 1'b1;
      end else begin
         r.m00 = rounded_ratio(w*w + x*x - y*y - z*z, n);
         r.m01 = rounded_ratio(2 * (x*y - w*z), n);
         r.m02 = rounded_ratio(2 * (x*z + w*y), n);
         r.m10 = rounded_ratio(2 * (x*y + w*z), n);
         r.m11 = rounded_ratio(w*w - x*x + y*y - z*z, n);
         r.m12 = rounded_ratio(2 * (y*z - w*x), n);
         r.m20 = rounded_ratio(2 * (x*z - w*y), n);
         r.m21 = rounded_ratio(2 * (y*z + w*x), n);
         r.m22 = rounded_ratio(w*w - x*x - y*y + z*z, n);
         r.status = 1'b0;
      end
      return r;
   endfunction

   // one request; bursts with random gaps
   task automatic send_request(req_type q);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      matrix_queue.insert(matrix_queue.size(), rotation_of(q));
      burst_left--;
   endtask

   function automatic logic signed [15:0] any_component();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return $signed(16'($urandom_range(0, 7))) - 16'sd3;
         3: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      req_type q;
      send_request('0);
      send_request({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      send_request({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
      send_request({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
      send_request({16'sd0, 16'sd0, 16'sd0, 16'sd1});
      send_request({16'sd1, 16'sd0, 16'sd0, 16'sd0});
      send_request({16'sd0, 16'sd1, 16'sd0, 16'sd0});
      send_request({16'sd0, 16'sd0, 16'sd1, 16'sd0});
      send_request({16'sd0, 16'sd0, 16'sd0, -16'sd1});
      send_request({16'sd1, 16'sd1, 16'sd1, 16'sd1});
      send_request({16'sd1, 16'sd2, 16'sd3, 16'sd4});
      send_request({16'sd3, 16'sd0, 16'sd0, 16'sd3});
      send_request({-16'sd1, 16'sd1, -16'sd1, 16'sd2});
      send_request({16'sh8000, 16'sd0, 16'sd0, 16'sd0});
      send_request({16'sd0, 16'sd0, 16'sd0, 16'sh7fff});
      send_request({16'sd0, 16'sh8000, 16'sd1, 16'sd0});
      q = '0;
      q.quat_z = 16'sh7fff;
      q.quat_w = 16'sh8000;
      send_request(q);
   endtask

   task automatic test_random();
      req_type q;
      repeat (2000) begin
         q.quat_x = any_component();
         q.quat_y = any_component();
         q.quat_z = any_component();
         q.quat_w = any_component();
         if ($urandom_range(0, 49) == 0) q = '0;
         send_request(q);
      end
      req_valid <= 1'b0;
   endtask

   // receiver stall pattern: phases of none, light, heavy
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (matrix_queue.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= 10)
               $display("unexpected matrix %h", rsp_data);
         end else begin
            expected = matrix_queue.pop_front();
            if (rsp_data !== expected) begin
               mismatch_count++;
               if (mismatch_count + unexpected_count <= 10)
                  $display("mismatch: expected %p actual %p", expected, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      burst_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && unexpected_count == 0 && matrix_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* sim.f */
design/qrm_pkg.sv
design/quaternion_to_rotation_matrix.sv
bench/tb_top.sv
